[src/gmt_pkg.sv]
// ----------------------------------------------------------------------------
// gmt_pkg: shared types and constants for the membership table merge
// Table depth, entry layout, result codes and register indexes.
// ----------------------------------------------------------------------------
package gmt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int IP_W   = 32;
   localparam int PORT_W = 16;
   localparam int HB_W   = 31;
   localparam int SLOT_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_IP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_PORT = 2'd1;

   localparam logic ACT_MERGE = 1'b0;
   localparam logic ACT_DEAD  = 1'b1;

   typedef enum logic [3:0] {
      OC_SELF       = 4'd0,
      OC_RAISED     = 4'd1,
      OC_ALIVE_SAME = 4'd2,
      OC_REVIVED    = 4'd3,
      OC_DEAD_SAME  = 4'd4,
      OC_INSERTED   = 4'd5,
      OC_FULL       = 4'd6,
      OC_MARKED     = 4'd7,
      OC_NOT_FOUND  = 4'd8
   } outcome_type;

   typedef struct packed {
      logic              alive;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic [HB_W-1:0]   heartbeat;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic             set_valid;
      logic [IDX_W-1:0] addr;
      entry_type        word;
   } table_wr_type;

endpackage

[src/gmt_table.sv]
// ----------------------------------------------------------------------------
// gmt_table: member table storage
// Entry memory with one registered read port and one write port, plus
// per-slot valid flags that reset clears.
// ----------------------------------------------------------------------------
module gmt_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [gmt_pkg::IDX_W-1:0] rd_addr,
   output gmt_pkg::entry_type        rd_data,
   output logic                      rd_valid,
   input  gmt_pkg::table_wr_type     wr
);
   import gmt_pkg::*;

   entry_type                mem [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   entry_type                rd_data_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.word;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en && wr.set_valid) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

[src/gossip_membership_table_merge_top.sv]
// ----------------------------------------------------------------------------
// gossip_membership_table_merge_top: gossip membership heartbeat merge
// Walks the member table with one address/port comparator, then merges,
// inserts or marks dead in a single write.
//
//   channel  | ports                                   | transfer
//   ---------+-----------------------------------------+---------------------
//   request  | start, busy, req_*                      | start && !busy
//   response | rsp_valid, rsp_*                        | rsp_valid (1 cycle)
//   config   | csr_valid, csr_ready, csr_index, wdata  | csr_valid && ready
//
// A self merge answers in the cycle after the transfer. Any other item makes
// one read per slot through the table's single registered read port, then
// decides and writes, then responds.
// Reset clears the valid flags at once; no sweep is needed.
// The receiver cannot stall; busy is high from transfer to decide.
// ----------------------------------------------------------------------------
module gossip_membership_table_merge_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [gmt_pkg::IP_W-1:0]        req_remote_ip,
   input  logic [gmt_pkg::PORT_W-1:0]      req_remote_port,
   input  logic [gmt_pkg::HB_W-1:0]        req_remote_heartbeat,
   output logic                            rsp_valid,
   output logic [3:0]                      rsp_outcome,
   output logic [gmt_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [gmt_pkg::HB_W-1:0]        rsp_stored_heartbeat,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gmt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gmt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gmt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [IP_W-1:0]   own_ip_ff;
   logic [PORT_W-1:0] own_port_ff;

   logic              act_ff, act_in;
   logic [IP_W-1:0]   ip_ff, ip_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic [HB_W-1:0]   hb_ff, hb_in;

   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  match_ff, match_in;
   entry_type         match_word_ff, match_word_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   outcome_type       rsp_outcome_ff, rsp_outcome_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [HB_W-1:0]   rsp_hb_ff, rsp_hb_in;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   entry_type         rd_data;
   logic              rd_valid;
   table_wr_type      wr;
   logic              accept;
   logic              is_self;
   logic              key_hit;

   gmt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .rd_valid (rd_valid),
      .wr       (wr)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign is_self   = (req_remote_ip == own_ip_ff) && (req_remote_port == own_port_ff);
   // the one shared comparator: key of the slot whose read returned
   assign key_hit   = rd_valid && (rd_data.ip == ip_ff) && (rd_data.port == port_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff   <= '0;
         own_port_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OWN_IP:   own_ip_ff   <= csr_wdata;
            CSR_OWN_PORT: own_port_ff <= csr_wdata[PORT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      ip_in          = ip_ff;
      port_in        = port_ff;
      hb_in          = hb_ff;
      issue_in       = issue_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      found_in       = found_ff;
      match_in       = match_ff;
      match_word_in  = match_word_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      rsp_valid_in   = 1'b0;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_hb_in      = rsp_hb_ff;
      rd_en          = 1'b0;
      rd_addr        = issue_ff[IDX_W-1:0];
      wr             = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in   = req_action;
               ip_in    = req_remote_ip;
               port_in  = req_remote_port;
               hb_in    = req_remote_heartbeat;
               issue_in = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
               if (req_action == ACT_MERGE && is_self) begin
                  rsp_valid_in   = 1'b1;
                  rsp_outcome_in = OC_SELF;
                  rsp_slot_in    = '0;
                  rsp_hb_in      = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff < CNT_W'(TABLE_ENTRIES)) begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               // keep the first hit and the first hole
               if (key_hit && !found_ff) begin
                  found_in      = 1'b1;
                  match_in      = pend_idx_ff;
                  match_word_in = rd_data;
               end
               if (!rd_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = pend_idx_ff;
               end
               if (pend_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_slot_in  = SLOT_W'(match_ff);
            rsp_hb_in    = match_word_ff.heartbeat;
            wr.addr      = match_ff;
            wr.word      = match_word_ff;
            if (act_ff == ACT_DEAD) begin
               if (found_ff) begin
                  wr.en          = 1'b1;
                  wr.word.alive  = 1'b0;
                  rsp_outcome_in = OC_MARKED;
               end else begin
                  rsp_outcome_in = OC_NOT_FOUND;
                  rsp_slot_in    = '0;
                  rsp_hb_in      = '0;
               end
            end else if (found_ff) begin
               if (match_word_ff.alive) begin
                  if (match_word_ff.heartbeat < hb_ff) begin
                     wr.en              = 1'b1;
                     wr.word.heartbeat  = hb_ff;
                     rsp_outcome_in     = OC_RAISED;
                     rsp_hb_in          = hb_ff;
                  end else begin
                     rsp_outcome_in = OC_ALIVE_SAME;
                  end
               end else if (match_word_ff.heartbeat != hb_ff) begin
                  wr.en             = 1'b1;
                  wr.word.alive     = 1'b1;
                  wr.word.heartbeat = hb_ff;
                  rsp_outcome_in    = OC_REVIVED;
                  rsp_hb_in         = hb_ff;
               end else begin
                  rsp_outcome_in = OC_DEAD_SAME;
               end
            end else if (free_ff) begin
               wr.en             = 1'b1;
               wr.set_valid      = 1'b1;
               wr.addr           = free_idx_ff;
               wr.word.alive     = 1'b1;
               wr.word.ip        = ip_ff;
               wr.word.port      = port_ff;
               wr.word.heartbeat = hb_ff;
               rsp_outcome_in    = OC_INSERTED;
               rsp_slot_in       = SLOT_W'(free_idx_ff);
               rsp_hb_in         = hb_ff;
            end else begin
               rsp_outcome_in = OC_FULL;
               rsp_slot_in    = '0;
               rsp_hb_in      = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      ip_ff          <= ip_in;
      port_ff        <= port_in;
      hb_ff          <= hb_in;
      pend_idx_ff    <= pend_idx_in;
      match_ff       <= match_in;
      match_word_ff  <= match_word_in;
      free_idx_ff    <= free_idx_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_hb_ff      <= rsp_hb_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = rsp_outcome_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_stored_heartbeat = rsp_hb_ff;

`ifndef ASSERT_OFF
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register lost its one-hot code");

   a_decide_returns: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |=> state_ff == ST_IDLE && rsp_valid)
      else $error("decide cycle did not produce a response");

   a_dead_scans: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACT_DEAD |=> busy && !rsp_valid)
      else $error("mark-dead request skipped the table walk");

   a_untouched_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome_ff == OC_SELF || rsp_outcome_ff == OC_FULL
                    || rsp_outcome_ff == OC_NOT_FOUND)
      |-> rsp_slot == '0 && rsp_stored_heartbeat == '0)
      else $error("response without a slot carries nonzero slot data");
`endif

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the gossip membership table merge
// Drives merge and mark-dead commands with random gaps. A shadow copy of the
// member table and the own address predicts each response. Every strobed
// response is checked field by field against the oldest prediction. The own
// address registers change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import gmt_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int TAIL_CYCLES = 80;
   localparam int POOL_KEYS   = 40;
   localparam int MAX_REPORTS = 10;

   // indexes that decode to no register; a write there must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic              action;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] port;
      logic [HB_W-1:0]   hb;
   } gossip_item_type;

   typedef struct {
      outcome_type       outcome;
      logic [SLOT_W-1:0] slot;
      logic [HB_W-1:0]   hb;
   } member_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_action = ACT_MERGE;
   logic [IP_W-1:0]        req_remote_ip = '0;
   logic [PORT_W-1:0]      req_remote_port = '0;
   logic [HB_W-1:0]        req_remote_heartbeat = '0;
   logic                   rsp_valid;
   logic [3:0]             rsp_outcome;
   logic [SLOT_W-1:0]      rsp_slot;
   logic [HB_W-1:0]        rsp_stored_heartbeat;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_OWN_IP;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow of the member table and the own address
   logic              tbl_valid [TABLE_ENTRIES];
   logic              tbl_alive [TABLE_ENTRIES];
   logic [IP_W-1:0]   tbl_ip    [TABLE_ENTRIES];
   logic [PORT_W-1:0] tbl_port  [TABLE_ENTRIES];
   logic [HB_W-1:0]   tbl_hb    [TABLE_ENTRIES];
   logic [IP_W-1:0]   own_ip_copy = '0;
   logic [PORT_W-1:0] own_port_copy = '0;

   gossip_item_type   pending_items [$];
   member_result_type expected_results [$];
   gossip_item_type   cur_item;

   // member keys that the random stimulus keeps hitting
   logic [IP_W-1:0]   key_ip   [POOL_KEYS];
   logic [PORT_W-1:0] key_port [POOL_KEYS];
   logic [HB_W-1:0]   key_hb   [POOL_KEYS];

   int  items_queued = 0;
   int  items_accepted = 0;
   int  error_count = 0;
   int  gap_left = 0;
   int  calm_left = 0;
   int  stall_cycles = 0;
   bit  drive_on;

   gossip_membership_table_merge_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_action           (req_action),
      .req_remote_ip        (req_remote_ip),
      .req_remote_port      (req_remote_port),
      .req_remote_heartbeat (req_remote_heartbeat),
      .rsp_valid            (rsp_valid),
      .rsp_outcome          (rsp_outcome),
      .rsp_slot             (rsp_slot),
      .rsp_stored_heartbeat (rsp_stored_heartbeat),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int find_member(input logic [IP_W-1:0] ip,
                                      input logic [PORT_W-1:0] port);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (tbl_valid[i] && tbl_ip[i] == ip && tbl_port[i] == port) return i;
      end
      return -1;
   endfunction

   // apply one command to the shadow table and return the response it gives
   function automatic member_result_type merge_member(input gossip_item_type it);
      member_result_type r;
      int hit;
      r.outcome = OC_NOT_FOUND;
      r.slot = '0;
      r.hb = '0;
      hit = -1;
      if (it.action == ACT_DEAD) begin
         hit = find_member(it.ip, it.port);
         if (hit >= 0) begin
            tbl_alive[hit] = 1'b0;
            r.outcome = OC_MARKED;
         end else begin
            r.outcome = OC_NOT_FOUND;
         end
      end else if (it.ip == own_ip_copy && it.port == own_port_copy) begin
         r.outcome = OC_SELF;
      end else begin
         hit = find_member(it.ip, it.port);
         if (hit >= 0) begin
            if (tbl_alive[hit]) begin
               if (tbl_hb[hit] < it.hb) begin
                  tbl_hb[hit] = it.hb;
                  r.outcome = OC_RAISED;
               end else begin
                  r.outcome = OC_ALIVE_SAME;
               end
            end else if (tbl_hb[hit] != it.hb) begin
               tbl_hb[hit] = it.hb;
               tbl_alive[hit] = 1'b1;
               r.outcome = OC_REVIVED;
            end else begin
               r.outcome = OC_DEAD_SAME;
            end
         end else begin
            // lowest free slot takes the new member
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (!tbl_valid[i] && hit < 0) hit = i;
            end
            if (hit < 0) begin
               r.outcome = OC_FULL;
            end else begin
               tbl_valid[hit] = 1'b1;
               tbl_alive[hit] = 1'b1;
               tbl_ip[hit] = it.ip;
               tbl_port[hit] = it.port;
               tbl_hb[hit] = it.hb;
               r.outcome = OC_INSERTED;
            end
         end
      end
      if (hit >= 0) begin
         r.slot = SLOT_W'(hit);
         r.hb = tbl_hb[hit];
      end
      return r;
   endfunction

   // driver: present the next pending command after its drawn gap
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         drive_on = start;
         if (start && !busy) begin
            expected_results = {expected_results, merge_member(cur_item)};
            items_accepted++;
            drive_on = 1'b0;
            if (calm_left > 0) begin
               gap_left = 0;
               calm_left--;
            end else begin
               gap_left = $urandom_range(0, 11);
               if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(8, 40);
            end
         end
         if (!drive_on) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               cur_item = pending_items.pop_front();
               req_action <= cur_item.action;
               req_remote_ip <= cur_item.ip;
               req_remote_port <= cur_item.port;
               req_remote_heartbeat <= cur_item.hb;
               drive_on = 1'b1;
            end
         end
         start <= drive_on;
      end
   end

   // monitor: every strobed response must match the oldest prediction
   always @(posedge clock) begin
      member_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected response: outcome %0d slot %0d heartbeat %0d",
                        rsp_outcome, rsp_slot, rsp_stored_heartbeat);
         end else begin
            want = expected_results.pop_front();
            if (rsp_outcome !== want.outcome || rsp_slot !== want.slot ||
                rsp_stored_heartbeat !== want.hb) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           want.outcome, want.slot, want.hb,
                           rsp_outcome, rsp_slot, rsp_stored_heartbeat);
            end
         end
      end
   end

   // watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL gossip_membership_table_merge_top");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_OWN_IP) own_ip_copy = data;
      else if (idx == CSR_OWN_PORT) own_port_copy = data[PORT_W-1:0];
      csr_valid <= 1'b0;
   endtask

   task automatic queue_item(input logic action, input logic [IP_W-1:0] ip,
                             input logic [PORT_W-1:0] port, input logic [HB_W-1:0] hb);
      gossip_item_type it;
      it.action = action;
      it.ip = ip;
      it.port = port;
      it.hb = hb;
      pending_items = {pending_items, it};
      items_queued++;
   endtask

   // mostly pool members with nearby heartbeats; the rest noise, near misses and own address
   task automatic queue_random(input int count, input int noise_pct, input int own_pct);
      int r;
      int k;
      int pick;
      logic action;
      logic [IP_W-1:0] ip;
      logic [PORT_W-1:0] port;
      logic [HB_W-1:0] hb;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         k = $urandom_range(0, POOL_KEYS - 1);
         action = ($urandom_range(0, 3) == 0) ? ACT_DEAD : ACT_MERGE;
         pick = $urandom_range(0, 9);
         if (pick == 0) hb = '0;
         else if (pick == 1) hb = '1;
         else hb = key_hb[k] + HB_W'($urandom_range(0, 7));
         ip = key_ip[k];
         port = key_port[k];
         if (r < noise_pct) begin
            action = 1'($urandom_range(0, 1));
            ip = $urandom;
            port = PORT_W'($urandom);
            hb = HB_W'($urandom);
         end else if (r < noise_pct + 5) begin
            // near miss: one address bit off
            if ($urandom_range(0, 1)) ip[$urandom_range(0, IP_W - 1)] ^= 1'b1;
            else port[$urandom_range(0, PORT_W - 1)] ^= 1'b1;
         end else if (r < noise_pct + 5 + own_pct) begin
            ip = own_ip_copy;
            port = own_port_copy;
         end
         queue_item(action, ip, port, hb);
      end
   endtask

   task automatic drain;
      while (items_accepted != items_queued || expected_results.size() > 0 || busy)
         @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
      for (int k = 0; k < POOL_KEYS; k++) begin
         key_ip[k] = $urandom;
         key_port[k] = PORT_W'($urandom);
         key_hb[k] = HB_W'($urandom);
         // neighbors that share the address or the port of the previous key
         if (k % 4 == 1) key_ip[k] = key_ip[k - 1];
         if (k % 4 == 2) key_port[k] = key_port[k - 1];
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: own address 0:0, extremes of every field
      write_csr(CSR_OWN_IP, '0);
      write_csr(CSR_OWN_PORT, '0);
      queue_item(ACT_MERGE, '0, '0, 31'd5);          // self merge
      queue_item(ACT_DEAD,  '0, '0, '1);             // mark dead skips self check
      queue_item(ACT_MERGE, '1, '1, '1);             // insert slot 0
      queue_item(ACT_MERGE, '1, '1, '0);             // not larger
      queue_item(ACT_MERGE, '0, '1, '0);             // insert slot 1
      queue_item(ACT_MERGE, '0, '1, 31'd1);          // raised
      queue_item(ACT_MERGE, '0, '1, 31'd1);          // equal on alive
      queue_item(ACT_MERGE, '1, '0, 31'd100);        // insert slot 2
      queue_item(ACT_DEAD,  '1, '0, '0);
      queue_item(ACT_DEAD,  '1, '0, '0);             // already dead
      queue_item(ACT_MERGE, '1, '0, 31'd100);        // dead, same heartbeat
      queue_item(ACT_MERGE, '1, '0, 31'd99);         // revived with a lower one
      queue_item(ACT_DEAD,  '1, '1, '0);
      queue_item(ACT_MERGE, '1, '1, '1);             // dead, same heartbeat
      queue_item(ACT_MERGE, '1, '1, '0);             // revived
      queue_item(ACT_DEAD,  32'h0123_4567, 16'h89ab, '0);  // no match
      queue_item(ACT_MERGE, 32'h0123_4567, 16'h89ab, '1);  // insert slot 3
      queue_item(ACT_MERGE, 32'h0123_4567, 16'h89ab, '1);
      drain();

      // own address outside the pool; fill the table with pool members
      write_csr(CSR_OWN_IP, $urandom);
      write_csr(CSR_OWN_PORT, $urandom);
      queue_random(300, 0, 3);
      drain();

      // own address equal to a stored member; noise fills the table
      write_csr(CSR_OWN_IP, '1);
      write_csr(CSR_OWN_PORT, '1);
      queue_random(300, 15, 8);
      drain();

      // unused indexes, then own port from a word with the high half set
      write_csr(CSR_SPARE_LO, $urandom);
      write_csr(CSR_SPARE_HI, '1);
      write_csr(CSR_OWN_IP, '0);
      write_csr(CSR_OWN_PORT, 32'hffff_0000);
      queue_random(300, 15, 8);
      drain();

      // own address taken from the pool
      write_csr(CSR_OWN_IP, key_ip[5]);
      write_csr(CSR_OWN_PORT, {16'h5a5a, key_port[5]});
      queue_random(350, 10, 5);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() > 0) begin
         error_count += expected_results.size();
         $display("%0d responses never arrived", expected_results.size());
      end
      if (error_count == 0) begin
         $display("PASS gossip_membership_table_merge_top");
      end else begin
         $display("FAIL gossip_membership_table_merge_top");
      end
      $finish;
   end

endmodule

[files.f]
src/gmt_pkg.sv
src/gmt_table.sv
src/gossip_membership_table_merge_top.sv
sim/tb_top.sv
